// ----- rtl/kad_pkg.sv -----
// kad_pkg: shared types and constants of the keypoint anchor decoder.
// Holds the transaction structs, register indexes, reset values and fixed widths.
// No dependencies.
package kad_pkg;

  // Fixed field widths
  localparam int unsigned OFF_W      = 16;
  localparam int unsigned SCORE_W    = 16;
  localparam int unsigned PIX_W      = 20;
  localparam int unsigned COEF_W     = 24;
  localparam int unsigned TRANS_W    = 20;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned LEVEL_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned NUM_CORNERS = 4;

  // Q.24 to Q.4 drops this many bits
  localparam int unsigned FRAC_SHIFT = 20;
  // Smallest stride is 8, a shift of 3
  localparam int unsigned BASE_SHIFT = 3;

  // Score sum and divide-by-three via reciprocal: floor(s * 349526 / 2^20) == s / 3
  // for every s below 2^19.
  localparam int unsigned SUM_W      = SCORE_W + 2;
  localparam int unsigned RECIP_W    = 19;
  localparam int unsigned PROD3_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP3 = 19'd349526;
  localparam int unsigned MEAN_SHIFT = 20;

  // Last pyramid level (strides 8, 16, 32)
  localparam logic [LEVEL_W-1:0] LEVEL_LAST = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AFF_XX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AFF_XY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AFF_XOFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AFF_YX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AFF_YY    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AFF_YOFF  = 3'd6;

  // Register reset values
  localparam logic [SCORE_W-1:0]       THRESHOLD_RST = 16'd29491;
  localparam logic signed [COEF_W-1:0] COEF_ONE      = 24'sd65536;
  localparam logic signed [COEF_W-1:0] COEF_ZERO     = 24'sd0;
  localparam logic signed [TRANS_W-1:0] TRANS_ZERO   = 20'sd0;

  typedef struct packed {
    logic signed [OFF_W-1:0] off_x1;
    logic signed [OFF_W-1:0] off_y1;
    logic signed [OFF_W-1:0] off_x2;
    logic signed [OFF_W-1:0] off_y2;
    logic signed [OFF_W-1:0] off_x3;
    logic signed [OFF_W-1:0] off_y3;
    logic signed [OFF_W-1:0] off_x4;
    logic signed [OFF_W-1:0] off_y4;
    logic [SCORE_W-1:0]      objectness;
    logic [SCORE_W-1:0]      color_score_a;
    logic [SCORE_W-1:0]      color_score_b;
    logic [SCORE_W-1:0]      class_score;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        anchor_index;
    logic signed [PIX_W-1:0] pix_x1;
    logic signed [PIX_W-1:0] pix_y1;
    logic signed [PIX_W-1:0] pix_x2;
    logic signed [PIX_W-1:0] pix_y2;
    logic signed [PIX_W-1:0] pix_x3;
    logic signed [PIX_W-1:0] pix_y3;
    logic signed [PIX_W-1:0] pix_x4;
    logic signed [PIX_W-1:0] pix_y4;
    logic                    color_id;
    logic [SCORE_W-1:0]      mean_prob;
  } out_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0]  xx;
    logic signed [COEF_W-1:0]  xy;
    logic signed [TRANS_W-1:0] x_off;
    logic signed [COEF_W-1:0]  yx;
    logic signed [COEF_W-1:0]  yy;
    logic signed [TRANS_W-1:0] y_off;
  } affine_t;

  // Load enables of the lane pipeline stages
  typedef struct packed {
    logic px;
    logic prod;
  } stage_en_t;

endpackage

// ----- rtl/kad_anchor_gen.sv -----
// kad_anchor_gen: grid position counters of the keypoint anchor decoder.
// Walks level, row, column and the running anchor index. Uses kad_pkg.
module kad_anchor_gen #(
  parameter int unsigned NET_WIDTH  = 416,
  parameter int unsigned NET_HEIGHT = 416,
  parameter int unsigned COL_W      = 6,
  parameter int unsigned ROW_W      = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  output logic [COL_W-1:0]              col_o,
  output logic [ROW_W-1:0]              row_o,
  output logic [kad_pkg::LEVEL_W-1:0]   level_o,
  output logic [kad_pkg::IDX_W-1:0]     index_o
);

  localparam logic [COL_W-1:0] LAST_COL0 = COL_W'(NET_WIDTH / 8 - 1);
  localparam logic [COL_W-1:0] LAST_COL1 = COL_W'(NET_WIDTH / 16 - 1);
  localparam logic [COL_W-1:0] LAST_COL2 = COL_W'(NET_WIDTH / 32 - 1);
  localparam logic [ROW_W-1:0] LAST_ROW0 = ROW_W'(NET_HEIGHT / 8 - 1);
  localparam logic [ROW_W-1:0] LAST_ROW1 = ROW_W'(NET_HEIGHT / 16 - 1);
  localparam logic [ROW_W-1:0] LAST_ROW2 = ROW_W'(NET_HEIGHT / 32 - 1);

  logic [COL_W-1:0]            col_q, col_d, last_col;
  logic [ROW_W-1:0]            row_q, row_d, last_row;
  logic [kad_pkg::LEVEL_W-1:0] level_q, level_d;
  logic [kad_pkg::IDX_W-1:0]   index_q, index_d;

  // Grid extent of the current level
  always_comb begin
    unique case (level_q)
      2'd0: begin
        last_col = LAST_COL0;
        last_row = LAST_ROW0;
      end
      2'd1: begin
        last_col = LAST_COL1;
        last_row = LAST_ROW1;
      end
      default: begin
        last_col = LAST_COL2;
        last_row = LAST_ROW2;
      end
    endcase
  end

  // Column, then row, then level; the index restarts with the frame
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    level_d = level_q;
    index_d = index_q;
    if (advance_i) begin
      index_d = index_q + 1'b1;
      if (col_q == last_col) begin
        col_d = '0;
        if (row_q == last_row) begin
          row_d = '0;
          if (level_q == kad_pkg::LEVEL_LAST) begin
            level_d = '0;
            index_d = '0;
          end else begin
            level_d = level_q + 1'b1;
          end
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      level_q <= '0;
      index_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      level_q <= level_d;
      index_q <= index_d;
    end
  end

  assign col_o   = col_q;
  assign row_o   = row_q;
  assign level_o = level_q;
  assign index_o = index_q;

endmodule

// ----- rtl/kad_lane.sv -----
// kad_lane: one corner lane of the keypoint anchor decoder.
// Scales the offset to pixels, applies the 2x3 affine and saturates to Q.4.
// Uses kad_pkg.
module kad_lane #(
  parameter int unsigned COL_W = 6,
  parameter int unsigned ROW_W = 6
) (
  input  logic                                clk_i,
  input  kad_pkg::stage_en_t                  en_i,
  input  logic signed [kad_pkg::OFF_W-1:0]    off_x_i,
  input  logic signed [kad_pkg::OFF_W-1:0]    off_y_i,
  input  logic [COL_W-1:0]                    col_i,
  input  logic [ROW_W-1:0]                    row_i,
  input  logic [kad_pkg::LEVEL_W-1:0]         level_i,
  input  kad_pkg::affine_t                    affine_i,
  output logic signed [kad_pkg::PIX_W-1:0]    pix_x_o,
  output logic signed [kad_pkg::PIX_W-1:0]    pix_y_o
);

  localparam int unsigned GRID_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int unsigned BASE_W   = ((GRID_W + 8 > 15) ? GRID_W + 8 : 15) + 2;
  localparam int unsigned PX_W     = BASE_W + 5;
  localparam int unsigned PROD_W   = PX_W + kad_pkg::COEF_W;
  localparam int unsigned TSH_W    = kad_pkg::TRANS_W + kad_pkg::FRAC_SHIFT;
  localparam int unsigned ACC_W    = ((PROD_W > TSH_W) ? PROD_W : TSH_W) + 2;
  localparam int unsigned Q_W      = ACC_W - kad_pkg::FRAC_SHIFT;
  localparam int          PIX_MAX  = (1 << (kad_pkg::PIX_W - 1)) - 1;
  localparam int          PIX_MIN  = -(1 << (kad_pkg::PIX_W - 1));
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(PIX_MAX);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(PIX_MIN);

  logic signed [BASE_W-1:0] base_x, base_y;
  logic [2:0]               shamt;
  logic signed [PX_W-1:0]   px_d, py_d, px_q, py_q;
  logic signed [PROD_W-1:0] p_xx_d, p_xy_d, p_yx_d, p_yy_d;
  logic signed [PROD_W-1:0] p_xx_q, p_xy_q, p_yx_q, p_yy_q;
  logic signed [ACC_W-1:0]  acc_x, acc_y;

  function automatic logic signed [kad_pkg::PIX_W-1:0] sat_q4(
    input logic signed [Q_W-1:0] v
  );
    logic signed [kad_pkg::PIX_W-1:0] r;
    if (v > Q_MAX) begin
      r = Q_MAX[kad_pkg::PIX_W-1:0];
    end else if (v < Q_MIN) begin
      r = Q_MIN[kad_pkg::PIX_W-1:0];
    end else begin
      r = v[kad_pkg::PIX_W-1:0];
    end
    return r;
  endfunction

  // Offset plus cell in Q.8, times the stride of the level
  assign shamt  = {1'b0, level_i} + 3'(kad_pkg::BASE_SHIFT);
  assign base_x = BASE_W'(off_x_i) + BASE_W'($signed({1'b0, col_i, 8'h00}));
  assign base_y = BASE_W'(off_y_i) + BASE_W'($signed({1'b0, row_i, 8'h00}));
  assign px_d   = PX_W'(base_x) <<< shamt;
  assign py_d   = PX_W'(base_y) <<< shamt;

  always_ff @(posedge clk_i) begin
    if (en_i.px) begin
      px_q <= px_d;
      py_q <= py_d;
    end
  end

  // Four coefficient products
  assign p_xx_d = PROD_W'(px_q) * PROD_W'(affine_i.xx);
  assign p_xy_d = PROD_W'(py_q) * PROD_W'(affine_i.xy);
  assign p_yx_d = PROD_W'(px_q) * PROD_W'(affine_i.yx);
  assign p_yy_d = PROD_W'(py_q) * PROD_W'(affine_i.yy);

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      p_xx_q <= p_xx_d;
      p_xy_q <= p_xy_d;
      p_yx_q <= p_yx_d;
      p_yy_q <= p_yy_d;
    end
  end

  // Sum with translation in Q.24, floor to Q.4, saturate
  assign acc_x = ACC_W'(p_xx_q) + ACC_W'(p_xy_q)
               + (ACC_W'(affine_i.x_off) <<< kad_pkg::FRAC_SHIFT);
  assign acc_y = ACC_W'(p_yx_q) + ACC_W'(p_yy_q)
               + (ACC_W'(affine_i.y_off) <<< kad_pkg::FRAC_SHIFT);

  assign pix_x_o = sat_q4($signed(acc_x[ACC_W-1:kad_pkg::FRAC_SHIFT]));
  assign pix_y_o = sat_q4($signed(acc_y[ACC_W-1:kad_pkg::FRAC_SHIFT]));

endmodule

// ----- rtl/keypoint_anchor_decode_top.sv -----
// keypoint_anchor_decode_top: top level of the keypoint anchor decoder.
// Instantiates kad_anchor_gen and four kad_lane corner lanes; uses kad_pkg.
//
// Takes one detector head row per cycle while in_ready_o is high and offers a
// result once the accepted row has passed the pipeline, only for anchors whose
// score mean reaches the threshold; others leave no result. The decode is a
// four-stage pipeline: score test and grid capture, pixel scaling, the affine
// products (four lanes of four 24-bit multipliers each, one lane per corner)
// and a merge into the output register. Each stage holds its item only while
// the stage after it is full and stalled, so input is still taken while a
// result waits as long as some stage is empty. Anchor position comes from
// internal counters in level, row, column order that restart with each frame;
// configuration writes are taken every cycle and must be made while idle.
module keypoint_anchor_decode_top #(
  parameter int unsigned NET_WIDTH  = 416,
  parameter int unsigned NET_HEIGHT = 416
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  kad_pkg::in_item_t                   in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output kad_pkg::out_item_t                  out_item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [kad_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [kad_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned COL_W = $clog2(NET_WIDTH / 8);
  localparam int unsigned ROW_W = $clog2(NET_HEIGHT / 8);

  // Configuration registers
  logic [kad_pkg::SCORE_W-1:0] thr_q;
  kad_pkg::affine_t            aff_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= kad_pkg::THRESHOLD_RST;
      aff_q.xx    <= kad_pkg::COEF_ONE;
      aff_q.xy    <= kad_pkg::COEF_ZERO;
      aff_q.x_off <= kad_pkg::TRANS_ZERO;
      aff_q.yx    <= kad_pkg::COEF_ZERO;
      aff_q.yy    <= kad_pkg::COEF_ONE;
      aff_q.y_off <= kad_pkg::TRANS_ZERO;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        kad_pkg::REG_THRESHOLD: thr_q       <= cfg_data_i[kad_pkg::SCORE_W-1:0];
        kad_pkg::REG_AFF_XX:    aff_q.xx    <= cfg_data_i;
        kad_pkg::REG_AFF_XY:    aff_q.xy    <= cfg_data_i;
        kad_pkg::REG_AFF_XOFF:  aff_q.x_off <= cfg_data_i[kad_pkg::TRANS_W-1:0];
        kad_pkg::REG_AFF_YX:    aff_q.yx    <= cfg_data_i;
        kad_pkg::REG_AFF_YY:    aff_q.yy    <= cfg_data_i;
        kad_pkg::REG_AFF_YOFF:  aff_q.y_off <= cfg_data_i[kad_pkg::TRANS_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or the next one is loading
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  logic in_fire;

  assign en4        = !v4_q || out_ready_i;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign in_fire    = in_valid_i && en1;

  // Anchor position counters
  logic [COL_W-1:0]            col_cur;
  logic [ROW_W-1:0]            row_cur;
  logic [kad_pkg::LEVEL_W-1:0] level_cur;
  logic [kad_pkg::IDX_W-1:0]   index_cur;

  kad_anchor_gen #(
    .NET_WIDTH  (NET_WIDTH),
    .NET_HEIGHT (NET_HEIGHT),
    .COL_W      (COL_W),
    .ROW_W      (ROW_W)
  ) u_anchor_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (in_fire),
    .col_o     (col_cur),
    .row_o     (row_cur),
    .level_o   (level_cur),
    .index_o   (index_cur)
  );

  // Score test: colour argmax, score sum against three times the threshold
  logic                        color_in;
  logic [kad_pkg::SUM_W-1:0]   sum_in, thr3;
  logic                        pass_in;

  assign color_in = in_item_i.color_score_b > in_item_i.color_score_a;
  assign sum_in   = kad_pkg::SUM_W'(in_item_i.objectness)
                  + kad_pkg::SUM_W'(color_in ? in_item_i.color_score_b
                                             : in_item_i.color_score_a)
                  + kad_pkg::SUM_W'(in_item_i.class_score);
  assign thr3     = kad_pkg::SUM_W'(thr_q) + kad_pkg::SUM_W'({thr_q, 1'b0});
  assign pass_in  = sum_in >= thr3;

  // Stage 1 to 4 payload
  kad_pkg::in_item_t           in1_q;
  logic [kad_pkg::SUM_W-1:0]   sum1_q;
  logic                        color1_q, color2_q, color3_q;
  logic [kad_pkg::IDX_W-1:0]   idx1_q, idx2_q, idx3_q;
  logic [COL_W-1:0]            col1_q;
  logic [ROW_W-1:0]            row1_q;
  logic [kad_pkg::LEVEL_W-1:0] level1_q;
  logic [kad_pkg::PROD3_W-1:0] recip2_q;
  logic [kad_pkg::SCORE_W-1:0] mean3_q;
  kad_pkg::out_item_t          out_q, out_d;

  // Valid bits; anchors below the threshold never enter the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i && pass_in;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Payload: input row, grid position, index, colour, the mean (reciprocal multiply by 1/3) and the result
  always_ff @(posedge clk_i) begin
    if (en1) begin
      in1_q    <= in_item_i;
      sum1_q   <= sum_in;
      color1_q <= color_in;
      idx1_q   <= index_cur;
      col1_q   <= col_cur;
      row1_q   <= row_cur;
      level1_q <= level_cur;
    end
    if (en2) begin
      recip2_q <= kad_pkg::PROD3_W'(sum1_q) * kad_pkg::PROD3_W'(kad_pkg::RECIP3);
      color2_q <= color1_q;
      idx2_q   <= idx1_q;
    end
    if (en3) begin
      mean3_q  <= recip2_q[kad_pkg::MEAN_SHIFT +: kad_pkg::SCORE_W];
      color3_q <= color2_q;
      idx3_q   <= idx2_q;
    end
    if (en4) begin
      out_q <= out_d;
    end
  end

  // Corner lanes
  logic signed [kad_pkg::OFF_W-1:0] off_x [kad_pkg::NUM_CORNERS];
  logic signed [kad_pkg::OFF_W-1:0] off_y [kad_pkg::NUM_CORNERS];
  logic signed [kad_pkg::PIX_W-1:0] pix_x [kad_pkg::NUM_CORNERS];
  logic signed [kad_pkg::PIX_W-1:0] pix_y [kad_pkg::NUM_CORNERS];
  kad_pkg::stage_en_t               lane_en;

  assign off_x[0] = in1_q.off_x1;
  assign off_y[0] = in1_q.off_y1;
  assign off_x[1] = in1_q.off_x2;
  assign off_y[1] = in1_q.off_y2;
  assign off_x[2] = in1_q.off_x3;
  assign off_y[2] = in1_q.off_y3;
  assign off_x[3] = in1_q.off_x4;
  assign off_y[3] = in1_q.off_y4;

  assign lane_en.px   = en2;
  assign lane_en.prod = en3;

  for (genvar g = 0; g < kad_pkg::NUM_CORNERS; g++) begin : g_lane
    kad_lane #(
      .COL_W (COL_W),
      .ROW_W (ROW_W)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (lane_en),
      .off_x_i  (off_x[g]),
      .off_y_i  (off_y[g]),
      .col_i    (col1_q),
      .row_i    (row1_q),
      .level_i  (level1_q),
      .affine_i (aff_q),
      .pix_x_o  (pix_x[g]),
      .pix_y_o  (pix_y[g])
    );
  end

  // Merge lanes and side payload into the result
  always_comb begin
    out_d.anchor_index = idx3_q;
    out_d.pix_x1       = pix_x[0];
    out_d.pix_y1       = pix_y[0];
    out_d.pix_x2       = pix_x[1];
    out_d.pix_y2       = pix_y[1];
    out_d.pix_x3       = pix_x[2];
    out_d.pix_y3       = pix_y[2];
    out_d.pix_x4       = pix_x[3];
    out_d.pix_y4       = pix_y[3];
    out_d.color_id     = color3_q;
    out_d.mean_prob    = mean3_q;
  end

  assign out_valid_o = v4_q;
  assign out_item_o  = out_q;

endmodule

// ----- sim/keypoint_anchor_decode_top_test.sv -----
// keypoint_anchor_decode_top_test: self-checking testbench of the keypoint anchor decoder.
// Drives anchor rows and register writes with random idling and back-pressure.
// Each detection is checked against an in-bench model; depends on kad_pkg and the top level.
module keypoint_anchor_decode_top_test;

  localparam int unsigned NET_W          = 416;
  localparam int unsigned NET_H          = 416;
  localparam int unsigned NUM_LEVELS     = 3;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PIPE_FLUSH     = 8;
  localparam int unsigned END_PAUSE      = 20;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASE_ITEMS    = 500;
  localparam logic [kad_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam longint PIX_MAX = 524287;
  localparam longint PIX_MIN = -524288;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready_o;
  kad_pkg::in_item_t  in_item = '0;
  logic               out_valid_o;
  logic               out_ready = 1'b0;
  kad_pkg::out_item_t out_item_o;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready_o;
  logic [kad_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [kad_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  keypoint_anchor_decode_top #(
    .NET_WIDTH (NET_W),
    .NET_HEIGHT(NET_H)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // Idling knobs, percent per cycle
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_rx = 1'b0;

  // Shadow registers and anchor position counters
  int unsigned cfg_threshold = kad_pkg::THRESHOLD_RST;
  longint cfg_xx = kad_pkg::COEF_ONE;
  longint cfg_xy = 0;
  longint cfg_xoff = 0;
  longint cfg_yx = 0;
  longint cfg_yy = kad_pkg::COEF_ONE;
  longint cfg_yoff = 0;
  int unsigned pos_level = 0;
  int unsigned pos_row = 0;
  int unsigned pos_col = 0;
  int unsigned pos_index = 0;

  kad_pkg::out_item_t pending_detections[$];
  int unsigned err_count = 0;
  int unsigned stall_cycles = 0;

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  // Q.24 affine sum to Q.4, floor then saturate
  function automatic logic signed [kad_pkg::PIX_W-1:0] affine_q4(
    longint coef_x, longint coef_y, longint shift_q4, longint px, longint py
  );
    longint acc;
    longint q;
    acc = coef_x * px + coef_y * py + (shift_q4 <<< kad_pkg::FRAC_SHIFT);
    q = acc >>> kad_pkg::FRAC_SHIFT;
    if (q > PIX_MAX) begin
      q = PIX_MAX;
    end else if (q < PIX_MIN) begin
      q = PIX_MIN;
    end
    return q[kad_pkg::PIX_W-1:0];
  endfunction

  // Works out the detection of one accepted anchor row and moves the position on
  task automatic predict_anchor(kad_pkg::in_item_t row);
    longint stride;
    int unsigned n_cols;
    int unsigned n_rows;
    int unsigned sum;
    logic pick_b;
    longint ox[kad_pkg::NUM_CORNERS];
    longint oy[kad_pkg::NUM_CORNERS];
    longint px;
    longint py;
    logic signed [kad_pkg::PIX_W-1:0] cx[kad_pkg::NUM_CORNERS];
    logic signed [kad_pkg::PIX_W-1:0] cy[kad_pkg::NUM_CORNERS];
    kad_pkg::out_item_t det;
    stride = longint'(1) <<< (kad_pkg::BASE_SHIFT + pos_level);
    n_cols = NET_W / int'(stride);
    n_rows = NET_H / int'(stride);
    pick_b = row.color_score_b > row.color_score_a;
    sum = int'(row.objectness) + int'(row.class_score) +
          (pick_b ? int'(row.color_score_b) : int'(row.color_score_a));
    if (sum >= 3 * cfg_threshold) begin
      ox = '{longint'(row.off_x1), longint'(row.off_x2), longint'(row.off_x3),
             longint'(row.off_x4)};
      oy = '{longint'(row.off_y1), longint'(row.off_y2), longint'(row.off_y3),
             longint'(row.off_y4)};
      for (int k = 0; k < kad_pkg::NUM_CORNERS; k++) begin
        px = (ox[k] + longint'(pos_col) * 256) * stride;
        py = (oy[k] + longint'(pos_row) * 256) * stride;
        cx[k] = affine_q4(cfg_xx, cfg_xy, cfg_xoff, px, py);
        cy[k] = affine_q4(cfg_yx, cfg_yy, cfg_yoff, px, py);
      end
      det = '0;
      det.anchor_index = pos_index[kad_pkg::IDX_W-1:0];
      det.pix_x1 = cx[0];
      det.pix_y1 = cy[0];
      det.pix_x2 = cx[1];
      det.pix_y2 = cy[1];
      det.pix_x3 = cx[2];
      det.pix_y3 = cy[2];
      det.pix_x4 = cx[3];
      det.pix_y4 = cy[3];
      det.color_id = pick_b;
      det.mean_prob = kad_pkg::SCORE_W'(sum / 3);
      pending_detections.insert(pending_detections.size(), det);
    end
    // level, row, column order; wrap to anchor 0 after the last level
    pos_col++;
    pos_index++;
    if (pos_col >= n_cols) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= n_rows) begin
        pos_row = 0;
        pos_level++;
        if (pos_level >= NUM_LEVELS) begin
          pos_level = 0;
          pos_index = 0;
        end
      end
    end
  endtask

  // Sends one anchor row; returns at the edge that accepts it
  task automatic send_anchor(kad_pkg::in_item_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= row;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_anchor(row);
  endtask

  // Register write; only called while the block is idle
  task automatic write_reg(logic [kad_pkg::CFG_IDX_W-1:0] idx,
                           logic [kad_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      kad_pkg::REG_THRESHOLD: cfg_threshold = data[kad_pkg::SCORE_W-1:0];
      kad_pkg::REG_AFF_XX:    cfg_xx = longint'($signed(data[kad_pkg::COEF_W-1:0]));
      kad_pkg::REG_AFF_XY:    cfg_xy = longint'($signed(data[kad_pkg::COEF_W-1:0]));
      kad_pkg::REG_AFF_XOFF:  cfg_xoff = longint'($signed(data[kad_pkg::TRANS_W-1:0]));
      kad_pkg::REG_AFF_YX:    cfg_yx = longint'($signed(data[kad_pkg::COEF_W-1:0]));
      kad_pkg::REG_AFF_YY:    cfg_yy = longint'($signed(data[kad_pkg::COEF_W-1:0]));
      kad_pkg::REG_AFF_YOFF:  cfg_yoff = longint'($signed(data[kad_pkg::TRANS_W-1:0]));
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Stop sending, wait for all detections, then let rows without one flush out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_detections.size() != 0) @(posedge clk_i);
    repeat (PIPE_FLUSH) @(posedge clk_i);
  endtask

  function automatic kad_pkg::in_item_t make_row(logic [15:0] ofs, logic [15:0] obj,
                                                 logic [15:0] sa, logic [15:0] sb,
                                                 logic [15:0] cls);
    kad_pkg::in_item_t row;
    row.off_x1 = ofs;
    row.off_y1 = ~ofs;
    row.off_x2 = ~ofs;
    row.off_y2 = ofs;
    row.off_x3 = ofs ^ 16'h0F0F;
    row.off_y3 = ofs ^ 16'hF0F0;
    row.off_x4 = ofs ^ 16'h00FF;
    row.off_y4 = ofs ^ 16'hFF00;
    row.objectness = obj;
    row.color_score_a = sa;
    row.color_score_b = sb;
    row.class_score = cls;
    return row;
  endfunction

  function automatic logic [15:0] rand_offset();
    case ($urandom_range(19))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Scores near or above the threshold for hot rows, anything otherwise
  function automatic logic [15:0] rand_score(bit hot);
    if (hot) begin
      return 16'($urandom_range(65535, cfg_threshold));
    end
    return 16'($urandom());
  endfunction

  function automatic kad_pkg::in_item_t rand_row(int unsigned hot_pct);
    kad_pkg::in_item_t row;
    bit hot;
    hot = $urandom_range(99) < hot_pct;
    row.off_x1 = rand_offset();
    row.off_y1 = rand_offset();
    row.off_x2 = rand_offset();
    row.off_y2 = rand_offset();
    row.off_x3 = rand_offset();
    row.off_y3 = rand_offset();
    row.off_x4 = rand_offset();
    row.off_y4 = rand_offset();
    row.objectness = rand_score(hot);
    row.color_score_a = rand_score(hot);
    row.color_score_b = ($urandom_range(9) == 0) ? row.color_score_a : rand_score(hot);
    row.class_score = rand_score(hot);
    return row;
  endfunction

  // Coefficients within +-2.0 in Q.16 half of the time, full range otherwise
  function automatic logic [kad_pkg::CFG_DATA_W-1:0] rand_coef();
    if ($urandom_range(1) == 0) begin
      return kad_pkg::CFG_DATA_W'($signed($urandom_range(262143)) - 131072);
    end
    return kad_pkg::CFG_DATA_W'($urandom());
  endfunction

  task automatic randomize_regs();
    logic [kad_pkg::CFG_DATA_W-1:0] thr_word;
    thr_word = kad_pkg::CFG_DATA_W'($urandom());
    thr_word[kad_pkg::SCORE_W-1:0] = 16'($urandom_range(45000));
    write_reg(kad_pkg::REG_THRESHOLD, thr_word);
    write_reg(kad_pkg::REG_AFF_XX, rand_coef());
    write_reg(kad_pkg::REG_AFF_XY, rand_coef());
    write_reg(kad_pkg::REG_AFF_XOFF, kad_pkg::CFG_DATA_W'($urandom()));
    write_reg(kad_pkg::REG_AFF_YX, rand_coef());
    write_reg(kad_pkg::REG_AFF_YY, rand_coef());
    write_reg(kad_pkg::REG_AFF_YOFF, kad_pkg::CFG_DATA_W'($urandom()));
    if ($urandom_range(1) == 0) begin
      write_reg(REG_UNUSED, kad_pkg::CFG_DATA_W'($urandom()));
    end
  endtask

  // Reset configuration: offset extremes, threshold boundary, colour choice and tie
  task automatic test_reset_values();
    send_anchor(make_row(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_anchor(make_row(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_anchor(make_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_anchor(make_row(16'h1234, 16'd29491, 16'd29491, 16'd0, 16'd29491));
    send_anchor(make_row(16'h1234, 16'd29491, 16'd29491, 16'd0, 16'd29490));
    send_anchor(make_row(16'hFFFF, 16'd60000, 16'd100, 16'd60000, 16'd60000));
    send_anchor(make_row(16'h5A5A, 16'd60000, 16'd60000, 16'd59999, 16'd60000));
    send_anchor(make_row(16'hA5A5, 16'd40000, 16'd40000, 16'd40000, 16'd40000));
    wait_idle();
  endtask

  // Register extremes, saturation both ways, upper data bits and the unused index
  task automatic test_register_extremes();
    write_reg(kad_pkg::REG_THRESHOLD, 24'hFF0000);
    write_reg(kad_pkg::REG_AFF_XX, 24'h7FFFFF);
    write_reg(kad_pkg::REG_AFF_XY, 24'h7FFFFF);
    write_reg(kad_pkg::REG_AFF_XOFF, 24'hF7FFFF);
    write_reg(kad_pkg::REG_AFF_YX, 24'h800000);
    write_reg(kad_pkg::REG_AFF_YY, 24'h800000);
    write_reg(kad_pkg::REG_AFF_YOFF, 24'h080000);
    write_reg(REG_UNUSED, 24'hFFFFFF);
    send_anchor(make_row(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_anchor(make_row(16'h8000, 16'h0000, 16'h0001, 16'h0000, 16'h0000));
    send_anchor(rand_row(0));
    send_anchor(rand_row(0));
    wait_idle();
    write_reg(kad_pkg::REG_THRESHOLD, 24'h00FFFF);
    write_reg(kad_pkg::REG_AFF_XX, 24'h000000);
    write_reg(kad_pkg::REG_AFF_XY, 24'h000000);
    write_reg(kad_pkg::REG_AFF_XOFF, 24'h07FFFF);
    write_reg(kad_pkg::REG_AFF_YX, 24'h000000);
    write_reg(kad_pkg::REG_AFF_YY, 24'h000000);
    write_reg(kad_pkg::REG_AFF_YOFF, 24'hF80000);
    send_anchor(make_row(16'h0F0F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_anchor(make_row(16'h0F0F, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFE));
    send_anchor(make_row(16'h0F0F, 16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF));
    wait_idle();
    write_reg(kad_pkg::REG_THRESHOLD, 24'h000000);
    write_reg(kad_pkg::REG_AFF_XX, 24'h010000);
    write_reg(kad_pkg::REG_AFF_YY, 24'h010000);
    write_reg(kad_pkg::REG_AFF_XOFF, 24'h000000);
    write_reg(kad_pkg::REG_AFF_YOFF, 24'h000000);
    send_anchor(make_row(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_anchor(make_row(16'h8000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
    wait_idle();
  endtask

  // Random rows under random configurations, one idling pattern per phase
  task automatic test_random_traffic();
    int unsigned idle_mix[4][2] = '{'{0, 0}, '{67, 0}, '{0, 67}, '{23, 23}};
    for (int p = 0; p < 4; p++) begin
      randomize_regs();
      send_idle_pct = idle_mix[p][0];
      recv_stall_pct = idle_mix[p][1];
      repeat (PHASE_ITEMS) send_anchor(rand_row(50));
      wait_idle();
    end
  endtask

  // Receiver holds off while rows keep coming, so the pipeline fills and stalls
  task automatic test_backpressure();
    write_reg(kad_pkg::REG_THRESHOLD, 24'h000000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rx <= 1'b0;
      end
      begin
        repeat (40) send_anchor(rand_row(0));
      end
    join
    wait_idle();
  endtask

  // Walks the rest of the frame through every level and past the wrap
  task automatic test_frame_wrap();
    int unsigned prev_index;
    bit wrapped;
    randomize_regs();
    send_idle_pct = 23;
    recv_stall_pct = 23;
    wrapped = 1'b0;
    while (!wrapped) begin
      prev_index = pos_index;
      send_anchor(rand_row(30));
      wrapped = pos_index < prev_index;
    end
    repeat (60) send_anchor(rand_row(50));
    wait_idle();
  endtask

  // Result side: check each accepted detection, then pick next cycle's ready
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready) begin
      if (pending_detections.size() == 0) begin
        report_mismatch($sformatf("unexpected detection, anchor %0d", out_item_o.anchor_index));
      end else begin
        kad_pkg::out_item_t want;
        want = pending_detections.pop_front();
        compare_field("anchor_index", out_item_o.anchor_index, want.anchor_index);
        compare_field("pix_x1", out_item_o.pix_x1, want.pix_x1);
        compare_field("pix_y1", out_item_o.pix_y1, want.pix_y1);
        compare_field("pix_x2", out_item_o.pix_x2, want.pix_x2);
        compare_field("pix_y2", out_item_o.pix_y2, want.pix_y2);
        compare_field("pix_x3", out_item_o.pix_x3, want.pix_x3);
        compare_field("pix_y3", out_item_o.pix_y3, want.pix_y3);
        compare_field("pix_x4", out_item_o.pix_x4, want.pix_x4);
        compare_field("pix_y4", out_item_o.pix_y4, want.pix_y4);
        compare_field("color_id", out_item_o.color_id, want.color_id);
        compare_field("mean_prob", out_item_o.mean_prob, want.mean_prob);
      end
    end
    out_ready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL keypoint_anchor_decode_top");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Test sequence
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    test_frame_wrap();
    wait_idle();
    repeat (END_PAUSE) @(posedge clk_i);
    if (pending_detections.size() != 0) begin
      report_mismatch($sformatf("%0d detections never arrived", pending_detections.size()));
    end
    if (err_count == 0) begin
      $display("PASS keypoint_anchor_decode_top");
    end else begin
      $display("FAIL keypoint_anchor_decode_top");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/kad_pkg.sv
rtl/kad_anchor_gen.sv
rtl/kad_lane.sv
rtl/keypoint_anchor_decode_top.sv
sim/keypoint_anchor_decode_top_test.sv
